// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/brp_pkg.sv -----
// ---------------------------------------------------------------------------
// brp_pkg
// shared widths and codes for the buffer replacement policy block
// ---------------------------------------------------------------------------
package brp_pkg;

  localparam int unsigned CLUSTER_W = 16;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned SLOT_FIELD_W = 2;
  localparam int unsigned TOTAL_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned MODE_W = 2;

  localparam logic [OUTCOME_W-1:0] OUTCOME_HIT = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_FILL = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_REPLACE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FIFO = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LRU = 2'd1;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

endpackage

// ----- sv/brp_match.sv -----
// ---------------------------------------------------------------------------
// brp_match
// parallel tag compare over all slots, lowest valid match wins
// ---------------------------------------------------------------------------
module brp_match import brp_pkg::*; #(
  parameter int unsigned SLOTS = 4,
  parameter int unsigned TAG_BITS = 16,
  parameter int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic [SLOTS-1:0][TAG_BITS-1:0] tags_i,
  input  logic [SLOTS-1:0]               valid_i,
  input  logic [TAG_BITS-1:0]            tag_i,
  output logic                           hit_o,
  output logic [IDX_W-1:0]               hit_idx_o
);

  always_comb begin
    hit_o = 1'b0;
    hit_idx_o = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (valid_i[s] && (tags_i[s] == tag_i)) begin
        hit_o = 1'b1;
        hit_idx_o = IDX_W'(s);
      end
    end
  end

endmodule

// ----- sv/brp_victim.sv -----
// ---------------------------------------------------------------------------
// brp_victim
// minimum key search as a compare tree, lower index wins ties
// ---------------------------------------------------------------------------
module brp_victim import brp_pkg::*; #(
  parameter int unsigned SLOTS = 4,
  parameter int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic [SLOTS-1:0][TIME_W-1:0] keys_i,
  output logic [IDX_W-1:0]             victim_o
);

  localparam int unsigned LEAVES = 1 << IDX_W;

  logic [TIME_W-1:0] key_l [IDX_W+1][LEAVES];
  logic [IDX_W-1:0]  idx_l [IDX_W+1][LEAVES];

  always_comb begin
    for (int l = 0; l <= IDX_W; l++) begin
      for (int n = 0; n < LEAVES; n++) begin
        key_l[l][n] = '0;
        idx_l[l][n] = '0;
      end
    end
    // padded leaves carry the largest key so a real slot always wins
    for (int n = 0; n < LEAVES; n++) begin
      key_l[0][n] = (n < SLOTS) ? keys_i[n] : TIME_MAX;
      idx_l[0][n] = IDX_W'(n);
    end
    for (int l = 0; l < IDX_W; l++) begin
      for (int n = 0; n < (LEAVES >> (l + 1)); n++) begin
        if (key_l[l][2*n+1] < key_l[l][2*n]) begin
          key_l[l+1][n] = key_l[l][2*n+1];
          idx_l[l+1][n] = idx_l[l][2*n+1];
        end else begin
          key_l[l+1][n] = key_l[l][2*n];
          idx_l[l+1][n] = idx_l[l][2*n];
        end
      end
    end
  end

  assign victim_o = idx_l[IDX_W][0];

endmodule

// ----- sv/buffer_replacement_policy_top.sv -----
// a request is captured in the input register (in_valid_q, tag_q), then processed and its
//   result registered in the output register; a stalled output holds both registers
// throughput: one request per cycle while the output is not stalled, set by the combinational
//   tag compare, victim compare tree and slot state update in the processing stage
// reset: all slots empty, counters and request clock zero, policy fifo
// ---------------------------------------------------------------------------
// buffer_replacement_policy_top
// four-slot style associative buffer with fifo, lru or lfu replacement
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module buffer_replacement_policy_top import brp_pkg::*; #(
  parameter int unsigned SLOTS = 4,
  parameter int unsigned TAG_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [MODE_W-1:0]       cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CLUSTER_W-1:0]    cluster_id_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [OUTCOME_W-1:0]    outcome_o,
  output logic [SLOT_FIELD_W-1:0] slot_used_o,
  output logic [CLUSTER_W-1:0]    evicted_cluster_o,
  output logic [TOTAL_W-1:0]      replacement_total_o
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned FILL_W = $clog2(SLOTS + 1);

  logic [MODE_W-1:0] mode_q;

  logic                in_valid_q;
  logic [TAG_BITS-1:0] tag_q;

  logic [SLOTS-1:0][TAG_BITS-1:0] slot_tag_q, slot_tag_d;
  logic [SLOTS-1:0]               slot_valid_q, slot_valid_d;
  logic [SLOTS-1:0][TIME_W-1:0]   slot_load_q, slot_load_d;
  logic [SLOTS-1:0][TIME_W-1:0]   slot_last_q, slot_last_d;
  logic [SLOTS-1:0][COUNT_W-1:0]  slot_count_q, slot_count_d;
  logic [TIME_W-1:0]              clock_q, clock_d;
  logic [FILL_W-1:0]              filled_q, filled_d;
  logic [TOTAL_W-1:0]             replace_q, replace_d;

  logic                    out_valid_q;
  logic [OUTCOME_W-1:0]    outcome_q, outcome_d;
  logic [SLOT_FIELD_W-1:0] slot_used_q, slot_used_d;
  logic [CLUSTER_W-1:0]    evicted_q, evicted_d;
  logic [TOTAL_W-1:0]      total_q, total_d;

  logic                         advance;
  logic                         process;
  logic                         hit;
  logic [IDX_W-1:0]             hit_idx;
  logic [IDX_W-1:0]             victim_idx;
  logic [IDX_W-1:0]             target;
  logic [SLOTS-1:0][TIME_W-1:0] keys;
  logic                         fill_full;
  logic                         out_replace;
  logic                         fill_step;

  assign advance = !out_valid_q || out_ready_i;
  assign process = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  brp_match #(
    .SLOTS    (SLOTS),
    .TAG_BITS (TAG_BITS),
    .IDX_W    (IDX_W)
  ) u_match (
    .tags_i    (slot_tag_q),
    .valid_i   (slot_valid_q),
    .tag_i     (tag_q),
    .hit_o     (hit),
    .hit_idx_o (hit_idx)
  );

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      case (mode_q)
        MODE_FIFO: keys[s] = slot_load_q[s];
        MODE_LRU:  keys[s] = slot_last_q[s];
        default:   keys[s] = TIME_W'(slot_count_q[s]);
      endcase
    end
  end

  brp_victim #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_victim (
    .keys_i   (keys),
    .victim_o (victim_idx)
  );

  always_comb begin
    slot_tag_d = slot_tag_q;
    slot_valid_d = slot_valid_q;
    slot_load_d = slot_load_q;
    slot_last_d = slot_last_q;
    slot_count_d = slot_count_q;
    filled_d = filled_q;
    replace_d = replace_q;
    clock_d = (clock_q != TIME_MAX) ? clock_q + 1'b1 : clock_q;
    evicted_d = '0;
    target = hit_idx;
    if (hit) begin
      outcome_d = OUTCOME_HIT;
      slot_last_d[target] = clock_d;
      if (slot_count_q[target] != COUNT_MAX) begin
        slot_count_d[target] = slot_count_q[target] + 1'b1;
      end
    end else begin
      if (filled_q < FILL_W'(SLOTS)) begin
        outcome_d = OUTCOME_FILL;
        target = filled_q[IDX_W-1:0];
        filled_d = filled_q + 1'b1;
      end else begin
        outcome_d = OUTCOME_REPLACE;
        target = victim_idx;
        evicted_d = CLUSTER_W'(slot_tag_q[victim_idx]);
        if (replace_q != TOTAL_MAX) begin
          replace_d = replace_q + 1'b1;
        end
      end
      slot_tag_d[target] = tag_q;
      slot_valid_d[target] = 1'b1;
      slot_load_d[target] = clock_d;
      slot_last_d[target] = clock_d;
      slot_count_d[target] = COUNT_W'(1);
    end
    slot_used_d = SLOT_FIELD_W'(target);
    total_d = replace_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_FIFO;
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      slot_tag_q <= '0;
      slot_valid_q <= '0;
      slot_load_q <= '0;
      slot_last_q <= '0;
      slot_count_q <= '0;
      clock_q <= '0;
      filled_q <= '0;
      replace_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (process) begin
        slot_tag_q <= slot_tag_d;
        slot_valid_q <= slot_valid_d;
        slot_load_q <= slot_load_d;
        slot_last_q <= slot_last_d;
        slot_count_q <= slot_count_d;
        clock_q <= clock_d;
        filled_q <= filled_d;
        replace_q <= replace_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tag_q <= TAG_BITS'(cluster_id_i);
    end
    if (process) begin
      outcome_q <= outcome_d;
      slot_used_q <= slot_used_d;
      evicted_q <= evicted_d;
      total_q <= total_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign outcome_o = outcome_q;
  assign slot_used_o = slot_used_q;
  assign evicted_cluster_o = evicted_q;
  assign replacement_total_o = total_q;

  assign fill_full = (filled_q == FILL_W'(SLOTS));
  assign out_replace = out_valid_q && (outcome_q == OUTCOME_REPLACE);
  assign fill_step = process && !hit && !fill_full;

  `ASSERT_IMPLIES(a_fill_bound, clk_i, rst_ni, 1'b1, filled_q <= FILL_W'(SLOTS))
  `ASSERT_IMPLIES(a_valid_count, clk_i, rst_ni, 1'b1, $countones(slot_valid_q) == filled_q)
  `ASSERT_IMPLIES(a_replace_full, clk_i, rst_ni, out_replace, fill_full)
  `ASSERT_NEXT(a_fill_grows, clk_i, rst_ni, fill_step, filled_q == $past(filled_q) + 1'b1)

endmodule

// ----- tb/sv/buffer_replacement_policy_top_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// buffer_replacement_policy_top_tb
// drives cluster requests through the four-slot buffer under every policy
// setting and checks each outcome, slot, evicted cluster and replacement
// total against a cycle-free model of the slot state
// ---------------------------------------------------------------------------
module buffer_replacement_policy_top_tb;
  import brp_pkg::*;

  localparam int unsigned SLOTS = 4;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam logic [MODE_W-1:0] MODE_LFU = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [OUTCOME_W-1:0]    outcome;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [CLUSTER_W-1:0]    evicted;
    logic [TOTAL_W-1:0]      total;
  } result_t;

  class replacement_scoreboard;
    logic [MODE_W-1:0]    mode;
    logic [CLUSTER_W-1:0] tag [SLOTS];
    bit                   valid [SLOTS];
    logic [TIME_W-1:0]    load_time [SLOTS];
    logic [TIME_W-1:0]    last_use [SLOTS];
    logic [COUNT_W-1:0]   use_count [SLOTS];
    logic [TIME_W-1:0]    now;
    int unsigned          filled;
    logic [TOTAL_W-1:0]   replaced;
    result_t              expected_q [$];
    int unsigned          mismatches;
    int unsigned          checked;
    int unsigned          hits;
    int unsigned          fills;
    int unsigned          replacements;

    function new();
      mode = MODE_FIFO;
      for (int s = 0; s < SLOTS; s++) begin
        tag[s] = '0;
        valid[s] = 1'b0;
        load_time[s] = '0;
        last_use[s] = '0;
        use_count[s] = '0;
      end
      now = '0;
      filled = 0;
      replaced = '0;
      mismatches = 0;
      checked = 0;
      hits = 0;
      fills = 0;
      replacements = 0;
    endfunction

    function void fill_slot(int s, logic [CLUSTER_W-1:0] id);
      tag[s] = id;
      valid[s] = 1'b1;
      load_time[s] = now;
      last_use[s] = now;
      use_count[s] = COUNT_W'(1);
    endfunction

    function void note_request(logic [CLUSTER_W-1:0] id);
      result_t           r;
      bit                hit;
      int                found;
      logic [TIME_W-1:0] k;
      logic [TIME_W-1:0] best;
      if (now != TIME_MAX) now++;
      hit = 1'b0;
      found = 0;
      for (int s = 0; s < SLOTS; s++) begin
        if (!hit && valid[s] && tag[s] == id) begin
          hit = 1'b1;
          found = s;
        end
      end
      r.evicted = '0;
      if (hit) begin
        r.outcome = OUTCOME_HIT;
        last_use[found] = now;
        if (use_count[found] != COUNT_MAX) use_count[found]++;
        hits++;
      end else if (filled < SLOTS) begin
        r.outcome = OUTCOME_FILL;
        found = filled;
        fill_slot(found, id);
        filled++;
        fills++;
      end else begin
        r.outcome = OUTCOME_REPLACE;
        best = '0;
        for (int s = 0; s < SLOTS; s++) begin
          case (mode)
            MODE_FIFO: k = load_time[s];
            MODE_LRU: k = last_use[s];
            default: k = {{(TIME_W-COUNT_W){1'b0}}, use_count[s]};
          endcase
          if (s == 0 || k < best) begin
            best = k;
            found = s;
          end
        end
        r.evicted = tag[found];
        fill_slot(found, id);
        if (replaced != TOTAL_MAX) replaced++;
        replacements++;
      end
      r.slot = found[SLOT_FIELD_W-1:0];
      r.total = replaced;
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      bit      bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: outcome %0d slot %0d evicted %h total %0d",
                   got.outcome, got.slot, got.evicted, got.total);
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      bad = (got.outcome !== exp.outcome) || (got.slot !== exp.slot) ||
            (got.evicted !== exp.evicted) || (got.total !== exp.total);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: outcome %0d/%0d slot %0d/%0d evicted %h/%h total %0d/%0d",
                   $time, exp.outcome, got.outcome, exp.slot, got.slot,
                   exp.evicted, got.evicted, exp.total, got.total);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [MODE_W-1:0]       cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [CLUSTER_W-1:0]    cluster_id_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [OUTCOME_W-1:0]    outcome_o;
  logic [SLOT_FIELD_W-1:0] slot_used_o;
  logic [CLUSTER_W-1:0]    evicted_cluster_o;
  logic [TOTAL_W-1:0]      replacement_total_o;

  replacement_scoreboard sb = new();
  bit                    gaps_on = 1'b1;
  bit                    hold_off_pending = 1'b0;
  int unsigned           cycle_count = 0;
  int unsigned           requests_sent = 0;
  int unsigned           policy_writes = 0;
  logic [CLUSTER_W-1:0]  hot_ids [8];
  int unsigned           hot_count = 5;

  logic [CLUSTER_W-1:0] directed_ids [18] = '{
    16'h0000, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'hFFFF,
    16'h0001, 16'h0000, 16'h5555, 16'h8000, 16'h7FFF, 16'h0001,
    16'hFFFF, 16'hAAAA, 16'h8000, 16'h0000, 16'h3C3C, 16'hC3C3
  };

  buffer_replacement_policy_top u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .cluster_id_i        (cluster_id_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .outcome_o           (outcome_o),
    .slot_used_o         (slot_used_o),
    .evicted_cluster_o   (evicted_cluster_o),
    .replacement_total_o (replacement_total_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("buffer_replacement_policy_top regression: fail");
      $finish;
    end
  end

  // result side: random stalls plus a long hold-off in each phase that asks for one
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk_i);
      end else if (gaps_on && $urandom_range(99) < 9) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    result_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = '{outcome_o, slot_used_o, evicted_cluster_o, replacement_total_o};
      sb.check_result(seen);
    end
  end

  task automatic send_request(input logic [CLUSTER_W-1:0] id);
    cluster_id_i <= id;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(id);
    requests_sent++;
    if (gaps_on && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_policy(input logic [MODE_W-1:0] mode);
    wait_drain();
    cfg_wdata_i <= mode;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.mode = mode;
    policy_writes++;
  endtask

  // mostly a small working set so hits, fills and evictions all occur
  task automatic run_phase(input logic [MODE_W-1:0] mode, input int unsigned count,
                           input int unsigned quiet_items, input int hold_at);
    logic [CLUSTER_W-1:0] id;
    write_policy(mode);
    hot_count = $urandom_range(5, 8);
    for (int i = 0; i < 8; i++) hot_ids[i] = CLUSTER_W'($urandom());
    for (int i = 0; i < count; i++) begin
      gaps_on = (i >= quiet_items);
      if (i == hold_at) hold_off_pending = 1'b1;
      if ($urandom_range(99) < 75) id = hot_ids[$urandom_range(hot_count - 1)];
      else id = CLUSTER_W'($urandom());
      send_request(id);
    end
    in_valid_i <= 1'b0;
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_policy(MODE_FIFO);
    foreach (directed_ids[i]) send_request(directed_ids[i]);
    in_valid_i <= 1'b0;

    run_phase(MODE_LRU, 300, 150, -1);
    run_phase(MODE_LFU, 350, 0, 100);
    run_phase(MODE_SPARE, 300, 0, -1);
    run_phase(MODE_FIFO, 300, 0, -1);
    run_phase(MODE_LRU, 300, 0, 200);
    run_phase(MODE_LFU, 300, 0, -1);

    wait_drain();
    repeat (6) @(posedge clk_i);

    $display("%0d requests checked over %0d policy writes (fifo, lru, lfu, unused code)",
             sb.checked, policy_writes);
    $display("%0d hits, %0d free-slot loads, %0d replacements, %0d mismatches",
             sb.hits, sb.fills, sb.replacements, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("buffer_replacement_policy_top regression: pass");
    end else begin
      $display("buffer_replacement_policy_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/brp_pkg.sv
sv/brp_match.sv
sv/brp_victim.sv
sv/buffer_replacement_policy_top.sv
tb/sv/buffer_replacement_policy_top_tb.sv
